[hdl/register_allocator_lru_assert.svh]
// assertion macros for the lru register allocator checker
// expects clk_i and rst_ni in the scope of the use
`ifndef REGISTER_ALLOCATOR_LRU_ASSERT_SVH
`define REGISTER_ALLOCATOR_LRU_ASSERT_SVH

// property checked at every clock edge outside reset
`define RLA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RLA_ASSERT_NEXT(name, ante, cons, msg) \
  `RLA_ASSERT(name, (ante) |=> (cons), msg)

`endif

[hdl/rla_pkg.sv]
// shared types and constants of the lru register allocator
// no dependencies
`default_nettype none

package rla_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned OwnerW  = 16;
  localparam int unsigned MarkW   = 32;
  localparam int unsigned IdxOutW = 4;

  localparam logic [MarkW-1:0] MarkMax = 32'hFFFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CmdAlloc  = 2'd0,
    CmdFree   = 2'd1,
    CmdRename = 2'd2,
    CmdLookup = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [OwnerW-1:0] owner;
    logic [MarkW-1:0]  mark;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
    logic clr_next;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

[hdl/rla_table.sv]
// register table: owner and use mark per entry, one read and one write port
// uses rla_pkg; entries that were never written or were freed read as zero
`default_nettype none

module rla_table #(
  parameter int unsigned NumRegs = 16,
  parameter int unsigned IdxW    = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rla_pkg::tbl_ctrl_t   ctrl_i,
  input  wire logic [IdxW-1:0]      rd_addr_i,
  input  wire logic [IdxW-1:0]      wr_addr_i,
  input  wire rla_pkg::entry_t      wr_entry_i,
  output rla_pkg::entry_t           rd_entry_o
);
  import rla_pkg::*;

  entry_t              mem_q [NumRegs];
  entry_t              rd_data_q;
  logic                rd_valid_q;
  logic [NumRegs-1:0]  valid_q, valid_d;
  logic [IdxW-1:0]     next_addr;
  logic                next_ok;

  assign next_addr = wr_addr_i + IdxW'(1);
  assign next_ok   = ((IdxW+1)'(wr_addr_i) + (IdxW+1)'(1)) < (IdxW+1)'(NumRegs);

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.wr) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (ctrl_i.clr) begin
      valid_d[wr_addr_i] = 1'b0;
    end
    if (ctrl_i.clr_next && next_ok) begin
      valid_d[next_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctrl_i.rd) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[hdl/register_allocator_lru.sv]
// lru register allocator top level: command sequencer and output register
// uses rla_pkg and rla_table
//
// channel  direction  handshake                 word
// in       input      in_valid_i / in_ready_o   command, owner_id, wide, new_owner_id
// out      output     out_valid_o / out_ready_i reg_index, spill_needed, status
//
// one command at a time; the time from accept to result is set by the table scan, which ends
// at the first hit or the last entry and reads one entry per cycle through the single read
// port and compares it in one shared unit
// a wide allocate passes through an extra write state for the second entry of the pair
// reset empties the table at once through per-entry valid bits
// a result waiting on out_ready_i holds; the next command is taken meanwhile
`default_nettype none

module register_allocator_lru #(
  parameter int unsigned NUM_REGS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rla_pkg::CmdW-1:0]      command_i,
  input  wire logic [rla_pkg::OwnerW-1:0]    owner_id_i,
  input  wire logic                          wide_i,
  input  wire logic [rla_pkg::OwnerW-1:0]    new_owner_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rla_pkg::IdxOutW-1:0]        reg_index_o,
  output logic                               spill_needed_o,
  output logic                               status_o
);
  import rla_pkg::*;

  localparam int unsigned IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned CW = $clog2(NUM_REGS + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_REGS - 1);
  localparam logic [CW-1:0] CntEnd  = CW'(NUM_REGS);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StScan   = 5'b00010,
    StWrite  = 5'b00100,
    StWrite2 = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q;
  logic [OwnerW-1:0]    id_q, new_id_q;
  logic                 wide_q;
  logic [CW-1:0]        cnt_q;
  logic                 rlive_q;
  logic [IW-1:0]        ridx_q;
  entry_t               prev_q;
  logic [MarkW-1:0]     min_q;
  logic [IW-1:0]        minpos_q;
  logic [IW-1:0]        sel_q;
  logic                 hit_q;
  logic [MarkW-1:0]     hit_mark_q;
  logic [MarkW-1:0]     ctr_q;
  logic                 out_valid_q;
  logic [IdxOutW-1:0]   out_idx_q;
  logic                 out_spill_q, out_status_q;

  tbl_ctrl_t            tbl_ctrl;
  logic [IW-1:0]        wr_addr;
  entry_t               wr_entry, cur;

  logic                 is_alloc, free_hit, match, hit_now, consider, lt, upd, last;
  logic [MarkW-1:0]     cand_mark;
  logic [IW-1:0]        cand_idx;
  logic                 accept, load_out;

  rla_table #(
    .NumRegs (NUM_REGS),
    .IdxW    (IW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tbl_ctrl),
    .rd_addr_i  (cnt_q[IW-1:0]),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_entry_o (cur)
  );

  assign accept   = in_valid_i && in_ready_o;
  assign load_out = (state_q == StFinish) && (!out_valid_q || out_ready_i);
  assign is_alloc = (cmd_q == CmdAlloc);

  // shared scan unit: one entry per cycle
  always_comb begin
    if (wide_q) begin
      free_hit  = ridx_q[0] && (prev_q.owner == '0) && (cur.owner == '0);
      cand_mark = prev_q.mark;
      cand_idx  = ridx_q - IW'(1);
      consider  = ridx_q[0];
    end else begin
      free_hit  = (cur.owner == '0);
      cand_mark = cur.mark;
      cand_idx  = ridx_q;
      consider  = 1'b1;
    end
    match   = (id_q != '0) && (cur.owner == id_q);
    hit_now = is_alloc ? free_hit : match;
    lt      = cand_mark < min_q;
    upd     = is_alloc && consider && lt;
    last    = (ridx_q == LastIdx);
  end

  always_comb begin
    tbl_ctrl = '0;
    wr_addr  = sel_q;
    wr_entry = '{owner: id_q, mark: ctr_q};
    tbl_ctrl.rd = (state_q == StScan) && (cnt_q != CntEnd);
    case (state_q)
      StWrite: begin
        case (cmd_q)
          CmdAlloc: begin
            tbl_ctrl.wr = 1'b1;
          end
          CmdFree: begin
            tbl_ctrl.clr      = hit_q;
            tbl_ctrl.clr_next = hit_q && wide_q;
          end
          CmdRename: begin
            tbl_ctrl.wr = hit_q;
            wr_entry    = '{owner: new_id_q, mark: hit_mark_q};
          end
          CmdLookup: begin
            tbl_ctrl.wr = hit_q;
          end
          default: begin
            tbl_ctrl.wr = 1'b0;
          end
        endcase
      end
      StWrite2: begin
        tbl_ctrl.wr = 1'b1;
        wr_addr     = sel_q + IW'(1);
      end
      default: begin
        tbl_ctrl.wr = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (rlive_q && (hit_now || last)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        state_d = (is_alloc && wide_q) ? StWrite2 : StFinish;
      end
      StWrite2: begin
        state_d = StFinish;
      end
      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rlive_q     <= 1'b0;
      cnt_q       <= '0;
      ctr_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rlive_q <= tbl_ctrl.rd;
      if (accept) begin
        cnt_q <= '0;
      end else if (tbl_ctrl.rd) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (tbl_ctrl.wr && !(state_q == StWrite && cmd_q == CmdRename)) begin
        ctr_q <= ctr_q + MarkW'(1);
      end
      if ((state_q == StScan) && rlive_q && (hit_now || last)) begin
        hit_q <= hit_now;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_e'(command_i);
      id_q     <= owner_id_i;
      wide_q   <= wide_i;
      new_id_q <= new_owner_id_i;
      min_q    <= MarkMax;
      minpos_q <= '0;
    end else if ((state_q == StScan) && rlive_q) begin
      prev_q <= cur;
      if (upd) begin
        min_q    <= cand_mark;
        minpos_q <= cand_idx;
      end
      if (hit_now) begin
        sel_q      <= is_alloc ? cand_idx : ridx_q;
        hit_mark_q <= cur.mark;
      end else if (last) begin
        sel_q <= upd ? cand_idx : minpos_q;
      end
    end
    ridx_q <= cnt_q[IW-1:0];
    if (load_out) begin
      out_idx_q    <= (is_alloc || hit_q) ? IdxOutW'(sel_q) : '0;
      out_spill_q  <= is_alloc && !hit_q;
      out_status_q <= !is_alloc && !hit_q;
    end
  end

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = out_valid_q;
  assign reg_index_o    = out_idx_q;
  assign spill_needed_o = out_spill_q;
  assign status_o       = out_status_q;

endmodule

`default_nettype wire

[hdl/register_allocator_lru_chk.sv]
// port-level checker for the lru register allocator, bound to the top level
// uses rla_pkg widths and the macros of register_allocator_lru_assert.svh
`default_nettype none

`include "register_allocator_lru_assert.svh"

module register_allocator_lru_chk (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_o,
  input  wire logic [rla_pkg::CmdW-1:0]      command_i,
  input  wire logic [rla_pkg::OwnerW-1:0]    owner_id_i,
  input  wire logic                          wide_i,
  input  wire logic [rla_pkg::OwnerW-1:0]    new_owner_id_i,
  input  wire logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  input  wire logic [rla_pkg::IdxOutW-1:0]   reg_index_o,
  input  wire logic                          spill_needed_o,
  input  wire logic                          status_o
);

  // a miss reports register zero and never a spill
  `RLA_ASSERT(a_miss_word, (out_valid_o && status_o) |-> (reg_index_o == '0 && !spill_needed_o), "miss word carries index or spill")

  // one command at a time
  `RLA_ASSERT_NEXT(a_one_cmd, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

  // a new result only comes out of a command in progress
  `RLA_ASSERT(a_result_src, $rose(out_valid_o) |-> $past(!in_ready_o), "result without a command in progress")

  // a stalled result word holds
  `RLA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(reg_index_o) && $stable(spill_needed_o) && $stable(status_o), "stalled result changed")

endmodule

bind register_allocator_lru register_allocator_lru_chk u_chk (.*);

`default_nettype wire

[dv/register_allocator_lru_checker.sv]
`timescale 1ns / 1ps
// checker for the lru register allocator: watches both channels, keeps its own
// owner table, use marks and use counter, and compares every result word
// depends on rla_pkg
module register_allocator_lru_checker
  import rla_pkg::*;
#(
  parameter int unsigned NUM_REGS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_o,
  input  wire logic [CmdW-1:0]     command_i,
  input  wire logic [OwnerW-1:0]   owner_id_i,
  input  wire logic                wide_i,
  input  wire logic [OwnerW-1:0]   new_owner_id_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_ready_i,
  input  wire logic [IdxOutW-1:0]  reg_index_o,
  input  wire logic                spill_needed_o,
  input  wire logic                status_o,
  output int                       mismatches_o,
  output int                       pending_o
);

  typedef struct packed {
    logic [IdxOutW-1:0] idx;
    logic               spill;
    logic               status;
  } grant_t;

  logic [OwnerW-1:0] owner_q [NUM_REGS];
  logic [MarkW-1:0]  mark_q  [NUM_REGS];
  logic [MarkW-1:0]  mark_clock;
  grant_t            grants_due [$];

  task automatic clear_table();
    for (int i = 0; i < NUM_REGS; i++) begin
      owner_q[i] = '0;
      mark_q[i]  = '0;
    end
    mark_clock   = '0;
    grants_due.delete();
    mismatches_o = 0;
    pending_o    = 0;
  endtask

  task automatic stamp(input int i);
    mark_q[i]  = mark_clock;
    mark_clock = mark_clock + 1'b1;
  endtask

  task automatic apply_command(input cmd_e cmd, input logic [OwnerW-1:0] id,
                               input logic wd, input logic [OwnerW-1:0] nid,
                               output grant_t g);
    int slot;
    int victim;
    int hit;
    bit placed;
    logic [MarkW-1:0] least;
    g = '0;
    if (cmd == CmdAlloc) begin
      placed = 1'b0;
      victim = 0;
      slot   = 0;
      least  = MarkMax;
      for (int i = 0; i < NUM_REGS; i++) begin
        if (!placed && !(wd && (i % 2 != 0 || i + 1 >= NUM_REGS))) begin
          if (owner_q[i] == '0 && (!wd || owner_q[i+1] == '0)) begin
            placed = 1'b1;
            slot   = i;
          end else if (mark_q[i] < least) begin
            least  = mark_q[i];
            victim = i;
          end
        end
      end
      if (!placed) begin
        slot    = victim;
        g.spill = 1'b1;
      end
      owner_q[slot] = id;
      stamp(slot);
      if (wd && slot + 1 < NUM_REGS) begin
        owner_q[slot+1] = id;
        stamp(slot + 1);
      end
      g.idx = slot[IdxOutW-1:0];
    end else begin
      hit = -1;
      if (id != '0) begin
        for (int i = 0; i < NUM_REGS; i++) begin
          if (hit < 0 && owner_q[i] == id) hit = i;
        end
      end
      if (hit < 0) begin
        g.status = 1'b1;
      end else begin
        g.idx = hit[IdxOutW-1:0];
        case (cmd)
          CmdFree: begin
            owner_q[hit] = '0;
            mark_q[hit]  = '0;
            if (wd && hit + 1 < NUM_REGS) begin
              owner_q[hit+1] = '0;
              mark_q[hit+1]  = '0;
            end
          end
          CmdRename: begin
            owner_q[hit] = nid;
          end
          default: begin
            stamp(hit);
          end
        endcase
      end
    end
  endtask

  initial clear_table();

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t want;
    grant_t got;
    if (!rst_ni) begin
      clear_table();
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{idx: reg_index_o, spill: spill_needed_o, status: status_o};
        if (grants_due.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("unexpected result word: idx %0d spill %0b status %0b",
                     got.idx, got.spill, got.status);
          end
          mismatches_o++;
        end else begin
          want = grants_due.pop_front();
          pending_o--;
          if (got !== want) begin
            if (mismatches_o < 10) begin
              $display("mismatch at %0t: expected idx %0d spill %0b status %0b, got idx %0d spill %0b status %0b",
                       $realtime, want.idx, want.spill, want.status,
                       got.idx, got.spill, got.status);
            end
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        apply_command(cmd_e'(command_i), owner_id_i, wide_i, new_owner_id_i, want);
        grants_due.push_back(want);
        pending_o++;
      end
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// testbench top for the lru register allocator: directed and random command
// words with random idling on both channels; verdict from the checker
// depends on rla_pkg, register_allocator_lru and register_allocator_lru_checker
module tb;
  import rla_pkg::*;

  localparam int unsigned NUM_REGS   = 16;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RAND_WORDS = 550;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  cmd_e              command;
  logic [OwnerW-1:0] owner_id;
  logic              wide;
  logic [OwnerW-1:0] new_owner_id;
  logic              out_valid;
  logic              out_ready;
  logic [IdxOutW-1:0] reg_index;
  logic              spill_needed;
  logic              status;
  int                mismatches;
  int                pending;
  bit                steady_rx;
  logic [OwnerW-1:0] id_pool [24];

  register_allocator_lru #(.NUM_REGS(NUM_REGS)) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .owner_id_i     (owner_id),
    .wide_i         (wide),
    .new_owner_id_i (new_owner_id),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .reg_index_o    (reg_index),
    .spill_needed_o (spill_needed),
    .status_o       (status)
  );

  register_allocator_lru_checker #(.NUM_REGS(NUM_REGS)) u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .owner_id_i     (owner_id),
    .wide_i         (wide),
    .new_owner_id_i (new_owner_id),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .reg_index_o    (reg_index),
    .spill_needed_o (spill_needed),
    .status_o       (status),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(input cmd_e cmd, input logic [OwnerW-1:0] id, input logic wd,
                           input logic [OwnerW-1:0] nid, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    owner_id     <= id;
    wide         <= wd;
    new_owner_id <= nid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [OwnerW-1:0] pick_owner();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return OwnerW'($urandom_range(1, 65535));
    return id_pool[$urandom_range(0, 23)];
  endfunction

  initial begin : receiver
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ready <= (hold == 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (out_valid && out_ready) begin
        seen++;
        // long hold-off so the block fills and stalls its input
        if (seen == 150) hold = 60;
        else if (steady_rx) hold = 0;
        else hold = $urandom_range(0, 5);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int r;
    bit steady;
    cmd_e c;
    in_valid     = 1'b0;
    command      = CmdAlloc;
    owner_id     = '0;
    wide         = 1'b0;
    new_owner_id = '0;
    steady_rx    = 1'b0;
    rst_n        = 1'b0;
    foreach (id_pool[k]) id_pool[k] = OwnerW'($urandom_range(1, 65535));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // misses on an empty table, pairs, owner zero, rename to zero
    send_word(CmdLookup, 16'h0001, 1'b0, 16'h0000, 0);
    send_word(CmdFree,   16'hFFFF, 1'b1, 16'hFFFF, 0);
    send_word(CmdAlloc,  16'hFFFF, 1'b1, 16'h0000, 0);
    send_word(CmdAlloc,  16'h0001, 1'b0, 16'h0000, 0);
    send_word(CmdLookup, 16'hFFFF, 1'b0, 16'h0000, 0);
    send_word(CmdRename, 16'h0001, 1'b0, 16'hFFFF, 0);
    send_word(CmdLookup, 16'h0000, 1'b0, 16'h0000, 0);
    send_word(CmdRename, 16'h0000, 1'b0, 16'h0005, 0);
    send_word(CmdAlloc,  16'h0000, 1'b0, 16'h0000, 0);
    send_word(CmdFree,   16'hFFFF, 1'b1, 16'h0000, 0);
    send_word(CmdRename, 16'hFFFF, 1'b0, 16'h0000, 0);
    // fill with pairs, then evict narrow and wide
    for (int k = 0; k < NUM_REGS / 2; k++) begin
      send_word(CmdAlloc, OwnerW'(16'h0010 + k), 1'b1, 16'h0000, 0);
    end
    send_word(CmdAlloc,  16'h7F00, 1'b0, 16'h0000, 0);
    send_word(CmdAlloc,  16'h00FE, 1'b1, 16'h0000, 0);
    // wide free of an owner left only in the last entry
    send_word(CmdRename, 16'h0017, 1'b0, 16'h5555, 0);
    send_word(CmdFree,   16'h0017, 1'b1, 16'h0000, 0);
    send_word(CmdLookup, 16'h5555, 1'b0, 16'h0000, 0);
    send_word(CmdAlloc,  16'hAAAA, 1'b1, 16'hAAAA, 0);
    drain_results();

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == 275) drain_results();
      steady    = (n >= 350 && n < 420);
      steady_rx <= steady;
      r = $urandom_range(0, 99);
      if (r < 35) c = CmdAlloc;
      else if (r < 55) c = CmdFree;
      else if (r < 72) c = CmdRename;
      else c = CmdLookup;
      send_word(c, pick_owner(), ($urandom_range(0, 9) < 3),
                ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 23)]
                                           : pick_owner(),
                steady);
    end
    steady_rx <= 1'b0;
    drain_results();
    repeat (2 * NUM_REGS + 16) @(posedge clk);

    if (mismatches == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/rla_pkg.sv
hdl/rla_table.sv
hdl/register_allocator_lru.sv
hdl/register_allocator_lru_chk.sv
dv/register_allocator_lru_checker.sv
dv/tb.sv
